// File: hdl/deq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 40;

  // Operation codes on the input stream
  localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LIST      = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_POP_FRONT,
    CMD_WRITE_AT,
    CMD_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [VAL_W-1:0]       value;
    logic [IDX_W-1:0]       tail_idx;
  } cell_cmd_t;

endpackage

// File: hdl/deq_cell.sv
// One storage cell of the queue chain; position 0 holds the front entry.
module deq_cell
  import deq_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        idx,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic signed [VAL_W-1:0] head_data,
  output logic signed [VAL_W-1:0] data
);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  // Pick the next entry from the neighbors, the front cell or the command
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CMD_PUSH_FRONT: data_nxt = left_data;
      CMD_POP_FRONT:  data_nxt = right_data;
      CMD_WRITE_AT: begin
        if (idx == cmd.tail_idx) begin
          data_nxt = cmd.value;
        end
      end
      CMD_ROTATE: begin
        if (idx == cmd.tail_idx) begin
          data_nxt = head_data;
        end else begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hdl/deq_ctrl.sv
// Occupancy tracking, command decode, listing walk and the result register.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [VAL_W-1:0] out_element,
  output logic                    out_last,
  input  logic signed [VAL_W-1:0] head_data,
  output cell_cmd_t               cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        walk_r, walk_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_element_r, out_element_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_free;
  logic                    in_fire;
  logic                    is_full;
  logic                    is_empty;
  logic                    walk_done;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign walk_done = ((CNT_W'(walk_r) + CNT_W'(1)) == count_r);

  // Decode the beat and drive the cell chain
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    walk_nxt        = walk_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    cmd.op          = CMD_HOLD;
    cmd.value       = in_value;
    cmd.tail_idx    = count_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          out_status_nxt  = STAT_OK;
          case (in_func)
            FN_ADD_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cmd.op    = CMD_WRITE_AT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FN_ADD_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cmd.op    = CMD_PUSH_FRONT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FN_REM_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                cmd.op    = CMD_POP_FRONT;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FN_REM_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FN_LIST: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                walk_nxt  = '0;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
            end
          endcase
        end
      end
      ST_LIST: begin
        // Emit the front entry and rotate it to the back of the occupied run
        cmd.tail_idx = walk_done ? count_r[IDX_W-1:0] - IDX_W'(1)
                                 : count_r[IDX_W-1:0] - IDX_W'(1);
        if (out_free) begin
          cmd.op          = CMD_ROTATE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STAT_OK;
          out_element_nxt = head_data;
          out_last_nxt    = walk_done;
          walk_nxt        = walk_r + IDX_W'(1);
          if (walk_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

// File: hdl/double_ended_queue.sv
// Top level: bounded double-ended queue built from a chain of shifting cells.
// Add and remove: result in the cycle after the input beat; while the output is
//   not stalled, one such beat per cycle. List of n entries: n results, one per
//   unstalled cycle, via the listing state, then the result register; input is held
//   off while the chain rotates once around, which sets the listing rate.
// Reset (rst_n low, synchronous) empties the queue; cell contents are kept.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [2:0] func, [34:3] value, [39:35] zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // [1:0] status, [33:2] element, [39:34] zero
  output logic             out_tlast
);

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_q [DEPTH];
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] element;

  deq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tdata[FUNC_W-1:0]),
    .in_value    (in_tdata[FUNC_W+VAL_W-1:FUNC_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (status),
    .out_element (element),
    .out_last    (out_tlast),
    .head_data   (cell_q[0]),
    .cmd         (cmd)
  );

  // Build the cell chain; the front cell takes new data from the command
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cmd.value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data       (cell_q[i])
    );
  end

  assign out_tdata = {{(OUT_W-STAT_W-VAL_W){1'b0}}, element, status};

endmodule

// File: hdl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker
  import deq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  logic [FUNC_W-1:0] func;
  logic              single_op;
  logic              dead_op;

  assign func      = in_tdata[FUNC_W-1:0];
  assign single_op = (func == FN_ADD_BACK) || (func == FN_ADD_FRONT) ||
                     (func == FN_REM_FRONT) || (func == FN_REM_BACK);
  assign dead_op   = !single_op && (func != FN_LIST);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // Adds and removals answer with one closing beat in the next cycle
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && single_op |=> out_tvalid && out_tlast)
    else $error("add or remove gave no result in the next cycle");

  // Unused operation codes produce no beat
  a_dead: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && dead_op |=> !out_tvalid)
    else $error("unused code produced a result");

  // Error beats close the run and carry no element
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STAT_W-1:0] != STAT_OK) |->
      out_tlast && (out_tdata[STAT_W+VAL_W-1:STAT_W] == '0))
    else $error("error beat with element or open run");

  // Status never takes the unused code
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STAT_W-1:0] == STAT_OK) ||
                   (out_tdata[STAT_W-1:0] == STAT_EMPTY) ||
                   (out_tdata[STAT_W-1:0] == STAT_FULL))
    else $error("invalid status code");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
